>>> src/rmsprop_parameter_update_assert.svh
// Assertion macros used by the RMSprop update top level.
// Uses the including module's clock and reset signals.
`ifndef RMSPROP_PARAMETER_UPDATE_ASSERT_SVH
`define RMSPROP_PARAMETER_UPDATE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> src/rpu_pkg.sv
// Types and constants of the RMSprop parameter update block.
// No dependencies; used by every RTL file of the block.
`default_nettype none
package rpu_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_STEP_SIZE  = 2'd0;
   localparam logic [1:0] CSR_SMOOTHING  = 2'd1;
   localparam logic [1:0] CSR_STABILIZER = 2'd2;
   localparam logic [1:0] CSR_ACTIVE     = 2'd3;

   localparam logic [16:0] ONE_Q16 = 17'd65536;

   // Queue between front and back.
   localparam int QDEPTH = 4;
   localparam int QAW    = 2;

   typedef struct packed {
      logic [4:0]         param_index;
      logic signed [31:0] param_value;
      logic signed [31:0] grad_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_value;
      logic               index_error;
   } rsp_type;

   typedef struct packed {
      logic [23:0] step_size;
      logic [15:0] smoothing_factor;
      logic [31:0] stabilizer;
      logic [5:0]  active_count;
   } cfg_type;

   // Per-item data that the back end carries along.
   typedef struct packed {
      logic        err;
      logic        gneg;
      logic [31:0] gmag;
      logic [31:0] value;
   } pay_type;

   typedef struct packed {
      pay_type     pay;
      logic [48:0] s;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage
`default_nettype wire

>>> src/rpu_front.sv
// Front end: accepts words, checks the index, updates the squared-gradient store.
// Depends on rpu_pkg.
`default_nettype none
module rpu_front import rpu_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire req_type  req_payload,
   input  wire qstat_type qstat,
   output logic          push,
   output work_type      push_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic        a_valid_ff, a_valid_in;
   logic [4:0]  a_idx_ff;
   logic        a_err_ff, a_err_in;
   logic        a_gneg_ff;
   logic [31:0] a_gmag_ff, a_gmag_in;
   logic [31:0] a_value_ff;
   logic [46:0] a_g2_ff;
   logic [63:0] g_sq;
   logic        front_en;

   logic [47:0]      avg_mem_ff [DEPTH];
   logic [DEPTH-1:0] avg_vld_ff;
   logic [AW-1:0]    addr;
   logic [47:0]      avg_old, avg_new;
   logic [63:0]      t_old, t_new;
   logic [64:0]      t_sum;
   logic [16:0]      w_new;

   // The front advances whenever the queue has room.
   assign front_en  = !qstat.full;
   assign req_stall = !front_en;

   // Classify and square the gradient on entry.
   always_comb begin
      a_gmag_in = req_payload.grad_value[31] ? (~req_payload.grad_value + 32'd1)
                                             : req_payload.grad_value;
      g_sq      = {32'd0, a_gmag_in} * {32'd0, a_gmag_in};
      a_err_in  = ({1'b0, req_payload.param_index} >= cfg.active_count) ||
                  ({27'd0, req_payload.param_index} >= 32'(DEPTH));
      a_valid_in = req_valid && front_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (front_en) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_in) begin
         a_idx_ff   <= req_payload.param_index;
         a_err_ff   <= a_err_in;
         a_gneg_ff  <= req_payload.grad_value[31];
         a_gmag_ff  <= a_gmag_in;
         a_value_ff <= req_payload.param_value;
         a_g2_ff    <= g_sq[62:16];
      end
   end

   // Read, blend and write back the running average.
   always_comb begin
      addr    = a_idx_ff[AW-1:0];
      avg_old = avg_vld_ff[addr] ? avg_mem_ff[addr] : 48'd0;
      w_new   = ONE_Q16 - {1'b0, cfg.smoothing_factor};
      t_old   = {48'd0, cfg.smoothing_factor} * {16'd0, avg_old};
      t_new   = {47'd0, w_new} * {17'd0, a_g2_ff};
      t_sum   = {1'b0, t_old} + {1'b0, t_new};
      avg_new = t_sum[63:16];
   end

   assign push = a_valid_ff && front_en;

   always_comb begin
      push_data.pay.err   = a_err_ff;
      push_data.pay.gneg  = a_gneg_ff;
      push_data.pay.gmag  = a_gmag_ff;
      push_data.pay.value = a_value_ff;
      push_data.s         = {1'b0, avg_new} + {17'd0, cfg.stabilizer};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_vld_ff <= '0;
      end else if (push && !a_err_ff) begin
         avg_vld_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !a_err_ff) begin
         avg_mem_ff[addr] <= avg_new;
      end
   end

endmodule
`default_nettype wire

>>> src/rpu_queue.sv
// Short word queue between the front and back ends.
// Depends on rpu_pkg.
`default_nettype none
module rpu_queue import rpu_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   input  wire logic     pop,
   output work_type      head,
   output qstat_type     qstat
);
   work_type     mem_ff [QDEPTH];
   logic [QAW-1:0] wr_ff, rd_ff;
   logic [QAW:0]   cnt_ff;

   assign head        = mem_ff[rd_ff];
   assign qstat.full  = (cnt_ff == (QAW+1)'(QDEPTH));
   assign qstat.empty = (cnt_ff == '0);

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QAW+1)'(push) - (QAW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> src/rpu_back.sv
// Back end: pipelined square root, scaling, pipelined divide and saturation.
// Depends on rpu_pkg.
`default_nettype none
module rpu_back import rpu_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic [23:0] step_size,
   input  wire qstat_type qstat,
   input  wire work_type  head,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_type        rsp_payload
);
   localparam int SQ = 32;
   localparam int DV = 47;

   logic en;

   logic        sq_vld_ff [SQ+1];
   logic [63:0] sq_v_ff   [SQ+1];
   logic [63:0] sq_r_ff   [SQ+1];
   pay_type     sq_p_ff   [SQ+1];

   logic        dv_vld_ff [DV+1];
   logic [31:0] dv_rem_ff [DV+1];
   logic [46:0] dv_q_ff   [DV+1];
   logic [46:0] dv_n_ff   [DV+1];
   logic [31:0] dv_d_ff   [DV+1];
   pay_type     dv_p_ff   [DV+1];

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [31:0] root;
   logic [55:0] num;
   logic signed [48:0] res;
   rsp_type     rsp_in;

   // Whole back pipeline moves when the output register can take a word.
   assign en  = !rsp_valid_ff || !rsp_stall;
   assign pop = en && !qstat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (en) begin
         sq_vld_ff[0] <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         sq_v_ff[0] <= {1'b0, head.s, 14'd0};
         sq_r_ff[0] <= '0;
         sq_p_ff[0] <= head.pay;
      end
   end

   // One root digit per stage.
   for (genvar i = 0; i < SQ; i++) begin : g_sq
      localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2*i);
      logic [63:0] sq_sum, sq_v_in, sq_r_in;

      always_comb begin
         sq_sum = sq_r_ff[i] + SQ_BIT;
         if (sq_v_ff[i] >= sq_sum) begin
            sq_v_in = sq_v_ff[i] - sq_sum;
            sq_r_in = (sq_r_ff[i] >> 1) + SQ_BIT;
         end else begin
            sq_v_in = sq_v_ff[i];
            sq_r_in = sq_r_ff[i] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            sq_vld_ff[i+1] <= sq_vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_v_ff[i+1] <= sq_v_in;
            sq_r_ff[i+1] <= sq_r_in;
            sq_p_ff[i+1] <= sq_p_ff[i];
         end
      end
   end

   // Scale the gradient by the step size; a zero root counts as one.
   always_comb begin
      root = (sq_r_ff[SQ][31:0] == 32'd0) ? 32'd1 : sq_r_ff[SQ][31:0];
      num  = {32'd0, step_size} * {24'd0, sq_p_ff[SQ].gmag};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (en) begin
         dv_vld_ff[0] <= sq_vld_ff[SQ];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem_ff[0] <= '0;
         dv_q_ff[0]   <= '0;
         dv_n_ff[0]   <= num[55:9];
         dv_d_ff[0]   <= root;
         dv_p_ff[0]   <= sq_p_ff[SQ];
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar j = 0; j < DV; j++) begin : g_dv
      logic [32:0] dv_try;
      logic [31:0] dv_rem_in;
      logic [46:0] dv_q_in;

      always_comb begin
         dv_try  = {dv_rem_ff[j], dv_n_ff[j][DV-1-j]};
         dv_q_in = dv_q_ff[j];
         if (dv_try >= {1'b0, dv_d_ff[j]}) begin
            dv_rem_in        = 32'(dv_try - {1'b0, dv_d_ff[j]});
            dv_q_in[DV-1-j]  = 1'b1;
         end else begin
            dv_rem_in = dv_try[31:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j+1] <= 1'b0;
         end else if (en) begin
            dv_vld_ff[j+1] <= dv_vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[j+1] <= dv_rem_in;
            dv_q_ff[j+1]   <= dv_q_in;
            dv_n_ff[j+1]   <= dv_n_ff[j];
            dv_d_ff[j+1]   <= dv_d_ff[j];
            dv_p_ff[j+1]   <= dv_p_ff[j];
         end
      end
   end

   // Apply the step against the gradient sign and saturate; an index error keeps the value.
   always_comb begin
      if (dv_p_ff[DV].gneg) begin
         res = {{17{dv_p_ff[DV].value[31]}}, dv_p_ff[DV].value} + {2'b00, dv_q_ff[DV]};
      end else begin
         res = {{17{dv_p_ff[DV].value[31]}}, dv_p_ff[DV].value} - {2'b00, dv_q_ff[DV]};
      end
      rsp_in.index_error = dv_p_ff[DV].err;
      if (dv_p_ff[DV].err) begin
         rsp_in.new_value = dv_p_ff[DV].value;
      end else if (res > 49'sd2147483647) begin
         rsp_in.new_value = 32'sh7FFFFFFF;
      end else if (res < -49'sd2147483648) begin
         rsp_in.new_value = 32'sh80000000;
      end else begin
         rsp_in.new_value = res[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_vld_ff[DV];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

>>> src/rmsprop_parameter_update.sv
// RMSprop parameter update, fixed point: one word in, one word out.
// Throughput one word per cycle while rsp_stall is low; each word passes through the
// 32-stage square root and 47-stage divide pipelines in the back end.
// A four-word queue decouples the front end (store update) from the back end.
// Synchronous active-high reset clears the configuration to defaults, empties the
// pipelines and queue, and marks every squared-gradient average as zero.
`default_nettype none
module rmsprop_parameter_update import rpu_pkg::*; #(
   parameter int MAX_PARAMS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_payload
);
`include "rmsprop_parameter_update_assert.svh"

   localparam int DEPTH = (MAX_PARAMS < 32) ? MAX_PARAMS : 32;

   cfg_type   cfg_ff;
   qstat_type qstat;
   work_type  push_data, head;
   logic      push, pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size        <= 24'd16777;
         cfg_ff.smoothing_factor <= 16'd58982;
         cfg_ff.stabilizer       <= 32'd1;
         cfg_ff.active_count     <= 6'd32;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_STEP_SIZE:  cfg_ff.step_size        <= csr_data[23:0];
            CSR_SMOOTHING:  cfg_ff.smoothing_factor <= csr_data[15:0];
            CSR_STABILIZER: cfg_ff.stabilizer       <= csr_data;
            CSR_ACTIVE:     cfg_ff.active_count     <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   rpu_front #(.DEPTH(DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .qstat       (qstat),
      .push        (push),
      .push_data   (push_data)
   );

   rpu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   rpu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .step_size   (cfg_ff.step_size),
      .qstat       (qstat),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // The queue never overflows or underflows, its status is consistent, and a full queue stalls requests.
   `ASSERT_IMPL(a_no_overflow, push && !pop, !qstat.full)
   `ASSERT_IMPL(a_no_underflow, pop, !qstat.empty)
   `ASSERT_ALWAYS(a_status_sane, !(qstat.full && qstat.empty))
   `ASSERT_IMPL(a_stall_when_full, qstat.full, req_stall)

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the RMSprop parameter update block.
// Depends on rpu_pkg and rmsprop_parameter_update; predicts each result word in place.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import rpu_pkg::*;

   localparam int SLOTS       = 32;
   localparam int RANDOM_WORDS = 1750;
   localparam int LATENCY     = 83;
   localparam longint CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;

   rmsprop_parameter_update #(.MAX_PARAMS(SLOTS)) u_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   // Predictor state: register copies and the squared-gradient averages.
   logic [23:0] rate_q;
   logic [15:0] decay_q;
   logic [31:0] stab_q;
   logic [5:0]  active_q;
   logic [47:0] mean_sq [SLOTS];

   rsp_type expected_words[$];
   int      mismatches;
   bit      timed_out;
   bit      stall_enable;
   longint  cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v = v - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root;
   endfunction

   // Flag an inactive slot; else compute the new value, advance its running average.
   function automatic rsp_type update_param(input req_type w);
      rsp_type     r;
      logic        gneg;
      logic [63:0] gmag, g2, avg, s, root, q;
      longint      res;
      r.new_value = w.param_value;
      r.index_error = 1'b1;
      if ({1'b0, w.param_index} >= active_q) return r;
      gneg = w.grad_value[31];
      gmag = gneg ? {32'd0, -w.grad_value} : {32'd0, w.grad_value};
      if (gneg) gmag[63:32] = 0;
      g2 = (gmag * gmag) >> 16;
      avg = (64'(decay_q) * 64'(mean_sq[w.param_index])
             + 64'(17'd65536 - {1'b0, decay_q}) * g2) >> 16;
      mean_sq[w.param_index] = avg[47:0];
      s = 64'(avg[47:0]) + 64'(stab_q);
      root = int_sqrt(s << 14);
      if (root == 0) root = 1;
      q = (64'(rate_q) * gmag) / (root << 9);
      res = gneg ? longint'(w.param_value) + longint'(q)
                 : longint'(w.param_value) - longint'(q);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      r.new_value = res[31:0];
      r.index_error = 1'b0;
      return r;
   endfunction

   // Random idle burst, now and then, while stalls are enabled.
   task automatic sender_gap();
      int n;
      if (stall_enable && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Send one word; expectation is computed when it is accepted.
   // Valid stays high after the accept so that words can follow back to back.
   task automatic send_word(input req_type w, input bit has_typed, input rsp_type typed);
      rsp_type p;
      csr_write <= 1'b0;
      sender_gap();
      req_valid <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (req_stall);
      p = update_param(w);
      if (has_typed && p !== typed) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row mismatch: predicted %h typed %h", p, typed);
      end
      expected_words.push_back(p);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // The write enable is dropped by the next word that is sent.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      case (idx)
         CSR_STEP_SIZE:  rate_q = val[23:0];
         CSR_SMOOTHING:  decay_q = val[15:0];
         CSR_STABILIZER: stab_q = val;
         default:        active_q = val[5:0];
      endcase
   endtask

   function automatic logic [31:0] rand_grad();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         2: return 32'($signed($urandom_range(0, 400)) - 200);
         3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return 32'($signed($urandom_range(0, 131072)) - 65536);
      endcase
   endfunction

   // Result side: random stall bursts and in-order comparison.
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_payload);
         end else begin
            want = expected_words.pop_front();
            if (rsp_payload.new_value !== want.new_value
                || rsp_payload.index_error !== want.index_error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected value %h err %b, got value %h err %b",
                           want.new_value, want.index_error,
                           rsp_payload.new_value, rsp_payload.index_error);
            end
         end
      end
   end

   int stall_left;
   always @(posedge clock) begin
      if (reset || !stall_enable) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Directed table: index, value, gradient, typed result where obvious.
   typedef struct {
      req_type w;
      bit      has_typed;
      rsp_type typed;
   } row_type;

   initial begin
      row_type rows[$];
      row_type r;
      req_type w;
      int n;
      int k;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_STEP_SIZE;
      csr_data = '0;
      req_valid = 1'b0;
      req_payload = '0;
      mismatches = 0;
      timed_out = 1'b0;
      stall_enable = 1'b1;
      cycle_count = 0;
      rate_q = 24'd16777;
      decay_q = 16'd58982;
      stab_q = 32'd1;
      active_q = 6'd32;
      for (int i = 0; i < SLOTS; i++) mean_sq[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero gradient leaves the value unchanged after reset; then nonzero gradients.
      r.w = '{5'd0, 32'sh0001_0000, 32'sh0}; r.has_typed = 1;
      r.typed = '{32'sh0001_0000, 1'b0}; rows.push_back(r);
      r.w = '{5'd31, 32'sh7fff_ffff, 32'sh0}; r.typed = '{32'sh7fff_ffff, 1'b0};
      rows.push_back(r);
      r.w = '{5'd1, 32'sh8000_0000, 32'sh0}; r.typed = '{32'sh8000_0000, 1'b0};
      rows.push_back(r);
      r.has_typed = 0;
      r.w = '{5'd2, 32'sh0, 32'sh7fff_ffff}; rows.push_back(r);
      r.w = '{5'd3, 32'sh0, 32'sh8000_0000}; rows.push_back(r);
      r.w = '{5'd4, 32'sh8000_0000, 32'sh7fff_ffff}; rows.push_back(r);
      r.w = '{5'd5, 32'sh7fff_ffff, 32'sh8000_0000}; rows.push_back(r);
      r.w = '{5'd6, 32'sh0000_1234, 32'sh0000_0001}; rows.push_back(r);
      r.w = '{5'd6, 32'shffff_0000, 32'shffff_ffff}; rows.push_back(r);
      r.w = '{5'd31, 32'sh1234_5678, 32'sh0001_0000}; rows.push_back(r);
      foreach (rows[i]) send_word(rows[i].w, rows[i].has_typed, rows[i].typed);
      drain();

      // Slot out of range, a zero root with zero stabilizer, then a zero step size.
      write_reg(CSR_ACTIVE, 32'd1);
      write_reg(CSR_STABILIZER, 32'd0);
      write_reg(CSR_STEP_SIZE, 32'hff_ffff);
      write_reg(CSR_SMOOTHING, 32'd65535);
      send_word('{5'd1, 32'sh1234_5678, 32'sh0001_0000}, 1, '{32'sh1234_5678, 1'b1});
      send_word('{5'd31, 32'sh8000_0000, 32'shffff_ffff}, 1, '{32'sh8000_0000, 1'b1});
      send_word('{5'd0, 32'sh0, 32'sh0}, 1, '{32'sh0, 1'b0});
      send_word('{5'd7, 32'sh0, 32'sh0}, 1, '{32'sh0, 1'b1});
      drain();
      write_reg(CSR_ACTIVE, 32'd0);
      send_word('{5'd0, 32'sh0000_0042, 32'sh0001_0000}, 1, '{32'sh0000_0042, 1'b1});
      drain();
      write_reg(CSR_ACTIVE, 32'd63);
      write_reg(CSR_SMOOTHING, 32'd0);
      write_reg(CSR_STABILIZER, 32'hffff_ffff);
      write_reg(CSR_STEP_SIZE, 32'd0);
      send_word('{5'd9, 32'sh0, 32'sh7fff_ffff}, 1, '{32'sh0, 1'b0});
      send_word('{5'd31, 32'sh5555_aaaa, 32'shaaaa_5555}, 0, '0);
      drain();

      // Random phases over several settings; the sender waits dry between them.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_STEP_SIZE, 32'd16777);
               write_reg(CSR_SMOOTHING, 32'd58982);
               write_reg(CSR_STABILIZER, 32'd1);
               write_reg(CSR_ACTIVE, 32'd32);
            end
            1: write_reg(CSR_STEP_SIZE, 32'hff_ffff);
            2: begin
               write_reg(CSR_ACTIVE, $urandom_range(1, 31));
               write_reg(CSR_STABILIZER, $urandom());
            end
            3: begin
               write_reg(CSR_SMOOTHING, $urandom_range(0, 65535));
               write_reg(CSR_STEP_SIZE, $urandom_range(0, 24'hff_ffff));
            end
            4: begin
               write_reg(CSR_STABILIZER, 32'd0);
               write_reg(CSR_SMOOTHING, 32'd65535);
               write_reg(CSR_ACTIVE, 32'd32);
            end
            5: write_reg(CSR_STEP_SIZE, $urandom_range(1, 65535));
            default: begin
               write_reg(CSR_SMOOTHING, 32'd58982);
               write_reg(CSR_STABILIZER, 32'd1);
               stall_enable = 1'b0;
            end
         endcase
         n = RANDOM_WORDS / 7;
         for (k = 0; k < n; k++) begin
            w.param_index = $urandom_range(0, 31);
            w.param_value = $urandom_range(0, 7) == 0 ? 32'sh8000_0000 : $urandom();
            w.grad_value = rand_grad();
            send_word(w, 0, '0);
         end
         drain();
      end

      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
+incdir+src
src/rpu_pkg.sv
src/rpu_front.sv
src/rpu_queue.sv
src/rpu_back.sv
src/rmsprop_parameter_update.sv
tb/sv/testbench.sv
